[rtl/pte_pkg.sv]
// ----------------------------------------------------------------------------
// Permutation table engine package
// Shared widths, command codes, the decoded item record and range helper.
// ----------------------------------------------------------------------------
package pte_pkg;

    // Width of every stored image, position and value.
    localparam int VAL_W = 9;

    // Default table depth.
    localparam int MAX_POINTS_DEF = 256;

    // Command codes.
    localparam logic [2:0] CMD_LOAD    = 3'd0;
    localparam logic [2:0] CMD_APPLY   = 3'd1;
    localparam logic [2:0] CMD_COMPOSE = 3'd2;
    localparam logic [2:0] CMD_INVERT  = 3'd3;
    localparam logic [2:0] CMD_COMMIT  = 3'd4;
    localparam logic [2:0] CMD_READ    = 3'd5;

    // Decoded item held while the table read is in flight.
    typedef struct packed {
        logic [2:0]       cmd;
        logic [VAL_W-1:0] pos;
        logic [VAL_W-1:0] val;
        logic             err;
        logic             val_ok;
    } item_t;

    // True when v lies in 1..min(n, maxp).
    function automatic logic in_range(logic [VAL_W-1:0] v, logic [VAL_W-1:0] n,
                                      int unsigned maxp);
        logic ok;
        ok = (v != '0) && (v <= n) && (32'(v) <= maxp);
        return ok;
    endfunction

endpackage

[rtl/permutation_table_engine_core.sv]
// ----------------------------------------------------------------------------
// Permutation table engine core
// Two banks of permutation images with load, apply, compose, invert, commit
// and read commands, one result per item.
// ----------------------------------------------------------------------------
//
//  Channel   Signals                                    Direction
//  -------   ----------------------------------------   ---------
//  input     in_valid, in_ready, command, position,     in
//            image_value
//  result    out_valid, out_ready, entry_out,           out
//            range_error
//  config    cfg_valid, cfg_ready, cfg_data             in
//
// One item per cycle sustained while the output is not stalled; bank read at the
// accepting edge, then stage two modifies, writes back and loads the result register.
// Both banks are read at once, so a commit in flight never stalls the next item;
// the write of the item ahead is forwarded from a holding register.
// After reset a clearing pass writes identity into both banks; in_ready stays
// low during it, configuration writes are taken.
// A stalled output register holds the second stage, which holds the input.
module permutation_table_engine_core #(
    parameter int MAX_POINTS = pte_pkg::MAX_POINTS_DEF
) (
    input  logic                     clk,
    input  logic                     rst_n,
    // Item input
    input  logic                     in_valid,
    output logic                     in_ready,
    input  logic [2:0]               command,
    input  logic [pte_pkg::VAL_W-1:0] position,
    input  logic [pte_pkg::VAL_W-1:0] image_value,
    // Result output
    output logic                     out_valid,
    input  logic                     out_ready,
    output logic [pte_pkg::VAL_W-1:0] entry_out,
    output logic                     range_error,
    // Size register write
    input  logic                     cfg_valid,
    output logic                     cfg_ready,
    input  logic [pte_pkg::VAL_W-1:0] cfg_data
);

    localparam int AW = $clog2(MAX_POINTS);
    localparam int VW = pte_pkg::VAL_W;

    // Size register.
    logic [VW-1:0] size_reg;

    // Clearing pass.
    logic          clr_reg;
    logic          clr_next;
    logic [AW-1:0] clr_cnt_reg;
    logic [AW-1:0] clr_cnt_next;
    logic [VW-1:0] clr_val;

    // Stage two and output registers.
    logic            s2_valid_reg;
    logic            s2_valid_next;
    pte_pkg::item_t  s2_item_reg;
    pte_pkg::item_t  s1_item;
    logic [AW-1:0]   s2_addr_reg;
    logic            out_valid_reg;
    logic            out_valid_next;
    logic [VW-1:0]   entry_reg;
    logic            err_reg;
    logic            bank_sel_reg;
    logic            bank_sel_next;

    // Memory banks and their ports.
    logic [VW-1:0] bank0_mem [MAX_POINTS];
    logic [VW-1:0] bank1_mem [MAX_POINTS];
    logic [VW-1:0] rd0_reg;
    logic [VW-1:0] rd1_reg;
    logic          we0;
    logic          we1;
    logic [AW-1:0] wa0;
    logic [AW-1:0] wa1;
    logic [VW-1:0] wd0;
    logic [VW-1:0] wd1;

    // Forwarding of the write that coincided with the read.
    logic          fwd_valid_reg;
    logic          fwd_bank_reg;
    logic [AW-1:0] fwd_addr_reg;
    logic [VW-1:0] fwd_data_reg;

    // Handshake and stage-two decisions.
    logic          in_accept;
    logic          s2_adv;
    logic [AW-1:0] rd_addr;
    logic [VW-1:0] rd0_f;
    logic [VW-1:0] rd1_f;
    logic [VW-1:0] cur_data;
    logic [VW-1:0] s2_entry;
    logic          s2_wr_en;
    logic          s2_wr_bank;
    logic [AW-1:0] s2_wr_addr;
    logic [VW-1:0] s2_wr_data;
    logic          needs_pos;

    assign cfg_ready   = 1'b1;
    assign s2_adv      = s2_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready    = !clr_reg && (!s2_valid_reg || s2_adv);
    assign in_accept   = in_valid && in_ready;
    assign out_valid   = out_valid_reg;
    assign entry_out   = entry_reg;
    assign range_error = err_reg;

    // Decode the incoming item and pick the table address to read.
    always_comb
    begin
        needs_pos = (command == pte_pkg::CMD_LOAD)   || (command == pte_pkg::CMD_COMPOSE) ||
                    (command == pte_pkg::CMD_INVERT) || (command == pte_pkg::CMD_READ);
        s1_item.cmd    = command;
        s1_item.pos    = position;
        s1_item.val    = image_value;
        s1_item.err    = needs_pos &&
                         !pte_pkg::in_range(position, size_reg, MAX_POINTS);
        s1_item.val_ok = pte_pkg::in_range(image_value, size_reg, MAX_POINTS);
        if ((command == pte_pkg::CMD_APPLY) || (command == pte_pkg::CMD_COMPOSE))
        begin
            rd_addr = AW'(32'(image_value) - 32'd1);
        end
        else
        begin
            rd_addr = AW'(32'(position) - 32'd1);
        end
    end

    // Current entry, with the write of the item ahead forwarded.
    always_comb
    begin
        rd0_f = rd0_reg;
        rd1_f = rd1_reg;
        if (fwd_valid_reg && (fwd_addr_reg == s2_addr_reg))
        begin
            if (fwd_bank_reg)
            begin
                rd1_f = fwd_data_reg;
            end
            else
            begin
                rd0_f = fwd_data_reg;
            end
        end
        cur_data = bank_sel_reg ? rd1_f : rd0_f;
    end

    // Result and write-back of the item in stage two.
    always_comb
    begin
        s2_entry      = '0;
        s2_wr_en      = 1'b0;
        s2_wr_bank    = bank_sel_reg;
        s2_wr_addr    = AW'(32'(s2_item_reg.pos) - 32'd1);
        s2_wr_data    = s2_item_reg.val;
        bank_sel_next = bank_sel_reg;
        if (!s2_item_reg.err)
        begin
            unique case (s2_item_reg.cmd)
                pte_pkg::CMD_LOAD:
                begin
                    s2_wr_en = 1'b1;
                end
                pte_pkg::CMD_APPLY:
                begin
                    s2_entry = s2_item_reg.val_ok ? cur_data : s2_item_reg.val;
                end
                pte_pkg::CMD_COMPOSE:
                begin
                    s2_entry   = s2_item_reg.val_ok ? cur_data : s2_item_reg.val;
                    s2_wr_en   = 1'b1;
                    s2_wr_bank = !bank_sel_reg;
                    s2_wr_data = s2_entry;
                end
                pte_pkg::CMD_INVERT:
                begin
                    s2_wr_en   = pte_pkg::in_range(cur_data, size_reg, MAX_POINTS);
                    s2_wr_bank = !bank_sel_reg;
                    s2_wr_addr = AW'(32'(cur_data) - 32'd1);
                    s2_wr_data = s2_item_reg.pos;
                end
                pte_pkg::CMD_COMMIT:
                begin
                    bank_sel_next = !bank_sel_reg;
                end
                pte_pkg::CMD_READ:
                begin
                    s2_entry = cur_data;
                end
                default:
                begin
                    s2_entry = '0;
                end
            endcase
        end
        if (!s2_adv)
        begin
            s2_wr_en      = 1'b0;
            bank_sel_next = bank_sel_reg;
        end
    end

    // Bank write ports, shared between the clearing pass and stage two.
    always_comb
    begin
        clr_val = VW'(32'(clr_cnt_reg) + 32'd1);
        if (clr_reg)
        begin
            we0 = 1'b1;
            we1 = 1'b1;
            wa0 = clr_cnt_reg;
            wa1 = clr_cnt_reg;
            wd0 = clr_val;
            wd1 = clr_val;
        end
        else
        begin
            we0 = s2_wr_en && !s2_wr_bank;
            we1 = s2_wr_en && s2_wr_bank;
            wa0 = s2_wr_addr;
            wa1 = s2_wr_addr;
            wd0 = s2_wr_data;
            wd1 = s2_wr_data;
        end
    end

    // Control next values.
    always_comb
    begin
        clr_next     = clr_reg;
        clr_cnt_next = clr_cnt_reg;
        if (clr_reg)
        begin
            clr_cnt_next = clr_cnt_reg + AW'(1);
            if (clr_cnt_reg == AW'(MAX_POINTS - 1))
            begin
                clr_next = 1'b0;
            end
        end
        if (in_accept)
        begin
            s2_valid_next = 1'b1;
        end
        else if (s2_adv)
        begin
            s2_valid_next = 1'b0;
        end
        else
        begin
            s2_valid_next = s2_valid_reg;
        end
        if (s2_adv)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            size_reg      <= VW'(2);
            clr_reg       <= 1'b1;
            clr_cnt_reg   <= '0;
            s2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            bank_sel_reg  <= 1'b0;
            fwd_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                size_reg <= cfg_data;
            end
            clr_reg       <= clr_next;
            clr_cnt_reg   <= clr_cnt_next;
            s2_valid_reg  <= s2_valid_next;
            out_valid_reg <= out_valid_next;
            bank_sel_reg  <= bank_sel_next;
            if (in_accept)
            begin
                fwd_valid_reg <= s2_wr_en;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            s2_item_reg  <= s1_item;
            s2_addr_reg  <= rd_addr;
            fwd_bank_reg <= s2_wr_bank;
            fwd_addr_reg <= s2_wr_addr;
            fwd_data_reg <= s2_wr_data;
        end
        if (s2_adv)
        begin
            entry_reg <= s2_entry;
            err_reg   <= s2_item_reg.err;
        end
    end

    // Bank 0 memory.
    always_ff @(posedge clk)
    begin
        if (we0)
        begin
            bank0_mem[wa0] <= wd0;
        end
        if (in_accept)
        begin
            rd0_reg <= bank0_mem[rd_addr];
        end
    end

    // Bank 1 memory.
    always_ff @(posedge clk)
    begin
        if (we1)
        begin
            bank1_mem[wa1] <= wd1;
        end
        if (in_accept)
        begin
            rd1_reg <= bank1_mem[rd_addr];
        end
    end

`ifndef SYNTH
    // A flagged item always reports a zero entry.
    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && range_error |-> entry_out == '0)
        else $error("range error with nonzero entry");

    // A commit leaving stage two swaps the current bank.
    a_commit_flip: assert property (@(posedge clk) disable iff (!rst_n)
        s2_adv && !s2_item_reg.err && (s2_item_reg.cmd == pte_pkg::CMD_COMMIT)
        |=> bank_sel_reg != $past(bank_sel_reg))
        else $error("commit did not swap banks");

    // Outside the clearing pass an item writes at most one bank.
    a_one_bank: assert property (@(posedge clk) disable iff (!rst_n)
        !clr_reg |-> $onehot0({we0, we1}))
        else $error("both banks written by one item");

    // The clearing pass ends only after the last entry.
    a_clr_end: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(clr_reg) |-> $past(clr_cnt_reg) == AW'(MAX_POINTS - 1))
        else $error("clearing pass ended early");
`endif

endmodule

[sim/permutation_table_monitor.sv]
// ----------------------------------------------------------------------------
// Permutation table engine monitor
// Watches the item, result and size register channels of the engine. It keeps
// its own copy of both image banks and predicts one result per accepted item,
// then compares each returned result field by field against the oldest one.
// ----------------------------------------------------------------------------
module permutation_table_monitor #(
    parameter int MAX_POINTS = pte_pkg::MAX_POINTS_DEF
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    input  logic                      in_ready,
    input  logic [2:0]                command,
    input  logic [pte_pkg::VAL_W-1:0] position,
    input  logic [pte_pkg::VAL_W-1:0] image_value,
    input  logic                      out_valid,
    input  logic                      out_ready,
    input  logic [pte_pkg::VAL_W-1:0] entry_out,
    input  logic                      range_error,
    input  logic                      cfg_valid,
    input  logic                      cfg_ready,
    input  logic [pte_pkg::VAL_W-1:0] cfg_data,
    output int                        fail_count,
    output int                        outstanding
);

    localparam int VW = pte_pkg::VAL_W;

    typedef struct packed {
        logic [VW-1:0] entry;
        logic          err;
    } table_result_t;

    // Shadow copy of the two image banks, the current bank and the size.
    logic [VW-1:0] image_bank [2][MAX_POINTS];
    logic          active_bank;
    logic [VW-1:0] point_count;
    table_result_t pending_results [$];
    int            mismatches;

    // True when v is a point of 1..n.
    function automatic logic is_point(logic [VW-1:0] v, int unsigned n);
        return (v >= 1) && (int'(v) <= n);
    endfunction

    // Apply one item to the shadow banks and return the result it produces.
    function automatic table_result_t step_tables(logic [2:0] cmd,
                                                  logic [VW-1:0] pos,
                                                  logic [VW-1:0] val);
        int unsigned   n;
        logic          cur;
        logic          nxt;
        logic          uses_pos;
        logic [VW-1:0] img;
        table_result_t r;
        n = (int'(point_count) > MAX_POINTS) ? MAX_POINTS : point_count;
        cur = active_bank;
        nxt = ~active_bank;
        r = '0;
        uses_pos = (cmd == pte_pkg::CMD_LOAD) || (cmd == pte_pkg::CMD_COMPOSE) ||
                   (cmd == pte_pkg::CMD_INVERT) || (cmd == pte_pkg::CMD_READ);
        if (uses_pos && !is_point(pos, n)) begin
            r.err = 1'b1;
        end
        else begin
            case (cmd)
                pte_pkg::CMD_LOAD: image_bank[cur][pos - 1] = val;
                pte_pkg::CMD_APPLY, pte_pkg::CMD_COMPOSE:
                begin
                    // Values outside the points in use map to themselves.
                    r.entry = is_point(val, n) ? image_bank[cur][val - 1] : val;
                    if (cmd == pte_pkg::CMD_COMPOSE)
                        image_bank[nxt][pos - 1] = r.entry;
                end
                pte_pkg::CMD_INVERT:
                begin
                    // A stored image outside the points in use skips the write.
                    img = image_bank[cur][pos - 1];
                    if (is_point(img, n))
                        image_bank[nxt][img - 1] = pos;
                end
                pte_pkg::CMD_COMMIT: active_bank = nxt;
                pte_pkg::CMD_READ: r.entry = image_bank[cur][pos - 1];
                default: ;
            endcase
        end
        return r;
    endfunction

    // Predict on every accepted item and check every accepted result.
    always @(posedge clk or negedge rst_n)
    begin
        table_result_t want;
        table_result_t got;
        if (!rst_n) begin
            for (int i = 0; i < MAX_POINTS; i++) begin
                image_bank[0][i] = VW'(i + 1);
                image_bank[1][i] = VW'(i + 1);
            end
            active_bank = 1'b0;
            point_count = VW'(2);
            pending_results.delete();
            mismatches = 0;
            fail_count <= 0;
            outstanding <= 0;
        end
        else begin
            if (out_valid && out_ready) begin
                if (pending_results.size() == 0) begin
                    mismatches++;
                    $display("%0t: unexpected result, expected none, got entry %0d err %0b",
                             $time, entry_out, range_error);
                end
                else begin
                    want = pending_results.pop_front();
                    if (entry_out !== want.entry) begin
                        mismatches++;
                        $display("%0t: entry_out expected %0d, got %0d",
                                 $time, want.entry, entry_out);
                    end
                    if (range_error !== want.err) begin
                        mismatches++;
                        $display("%0t: range_error expected %0b, got %0b",
                                 $time, want.err, range_error);
                    end
                end
            end
            if (cfg_valid && cfg_ready)
                point_count = cfg_data;
            if (in_valid && in_ready) begin
                got = step_tables(command, position, image_value);
                pending_results.insert(pending_results.size(), got);
            end
            fail_count <= mismatches;
            outstanding <= pending_results.size();
        end
    end

endmodule

[sim/tb_permutation_table_engine_core.sv]
// ----------------------------------------------------------------------------
// Permutation table engine testbench
// Drives directed and random command streams with random idle gaps on both
// channels, changes the point count between phases while the engine is idle,
// and reports the verdict from the monitor's mismatch and outstanding counts.
// ----------------------------------------------------------------------------
module tb_permutation_table_engine_core;

    localparam int MAX_POINTS   = pte_pkg::MAX_POINTS_DEF;
    localparam int VW           = pte_pkg::VAL_W;
    localparam int TARGET_ITEMS = 1200;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int STREAM_MAX   = 32;

    logic          clk;
    logic          rst_n;
    logic          in_valid;
    logic          in_ready;
    logic [2:0]    command;
    logic [VW-1:0] position;
    logic [VW-1:0] image_value;
    logic          out_valid;
    logic          out_ready = 1'b0;
    logic [VW-1:0] entry_out;
    logic          range_error;
    logic          cfg_valid;
    logic          cfg_ready;
    logic [VW-1:0] cfg_data;

    int fail_count;
    int outstanding;
    int cycle_count = 0;
    int stall_left = 0;
    int run_left = 0;
    int counted_items;
    int cur_size;
    logic idle_on;
    int shuffle_buf [MAX_POINTS];

    permutation_table_engine_core #(
        .MAX_POINTS(MAX_POINTS)
    ) uut (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_ready(in_ready),
        .command(command),
        .position(position),
        .image_value(image_value),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .entry_out(entry_out),
        .range_error(range_error),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_data(cfg_data)
    );

    permutation_table_monitor #(
        .MAX_POINTS(MAX_POINTS)
    ) table_monitor (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_ready(in_ready),
        .command(command),
        .position(position),
        .image_value(image_value),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .entry_out(entry_out),
        .range_error(range_error),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_data(cfg_data),
        .fail_count(fail_count),
        .outstanding(outstanding)
    );

    // Free-running clock.
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Abort a hung run.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("[permutation_table_engine_core] ERROR");
            $finish;
        end
    end

    // Result side back pressure: runs of ready, short and long stalls.
    always @(posedge clk)
    begin
        int r;
        if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            out_ready <= 1'b0;
        end
        else if (run_left > 0) begin
            run_left <= run_left - 1;
            out_ready <= 1'b1;
        end
        else begin
            r = $urandom_range(0, 99);
            if (r < 15)
                run_left <= $urandom_range(40, 150);
            else if (r < 25)
                stall_left <= $urandom_range(10, 30);
            else if (r < 60)
                stall_left <= $urandom_range(1, 3);
            else
                run_left <= $urandom_range(1, 6);
            out_ready <= 1'b1;
        end
    end

    // Idle gap before a transaction: mostly none or short, a few long.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50)
            return 0;
        else if (r < 85)
            return $urandom_range(1, 3);
        else if (r < 95)
            return $urandom_range(4, 8);
        return $urandom_range(10, 30);
    endfunction

    // Image value for apply and compose, now and then beyond the points in use.
    function automatic int pick_image(int n);
        if ($urandom_range(0, 9) == 0)
            return $urandom_range(1, MAX_POINTS);
        return $urandom_range(1, n);
    endfunction

    // Send one item and wait until the engine takes it.
    task automatic send_item(input logic [2:0] cmd, input int pos, input int val);
        int   gap;
        logic uses_pos;
        gap = idle_on ? pick_gap() : 0;
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        command <= cmd;
        position <= VW'(pos);
        image_value <= VW'(val);
        do @(posedge clk); while (!in_ready);
        // Items the engine rejects or ignores do not count toward the target.
        uses_pos = (cmd == pte_pkg::CMD_LOAD) || (cmd == pte_pkg::CMD_COMPOSE) ||
                   (cmd == pte_pkg::CMD_INVERT) || (cmd == pte_pkg::CMD_READ);
        if (cmd <= pte_pkg::CMD_READ && (!uses_pos || (pos >= 1 && pos <= cur_size)))
            counted_items++;
    endtask

    // Stop sending and wait until every predicted result has come back.
    task automatic drain_results();
        in_valid <= 1'b0;
        do @(posedge clk); while (outstanding != 0);
    endtask

    // Change the point count once the engine is idle.
    task automatic write_size(input int n);
        drain_results();
        cfg_valid <= 1'b1;
        cfg_data <= VW'(n);
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        cur_size = n;
    endtask

    // Fill shuffle_buf[0..n-1] with a random ordering of 1..n.
    task automatic shuffle_points(input int n);
        int j;
        int t;
        for (int i = 0; i < n; i++)
            shuffle_buf[i] = i + 1;
        for (int i = n - 1; i > 0; i--) begin
            j = $urandom_range(0, i);
            t = shuffle_buf[i];
            shuffle_buf[i] = shuffle_buf[j];
            shuffle_buf[j] = t;
        end
    endtask

    // Load a full random permutation, or scattered entries when n is large.
    task automatic load_permutation(input int n);
        if (n <= STREAM_MAX) begin
            shuffle_points(n);
            for (int i = 0; i < n; i++)
                send_item(pte_pkg::CMD_LOAD, i + 1, shuffle_buf[i]);
        end
        else begin
            repeat (24) send_item(pte_pkg::CMD_LOAD, $urandom_range(1, n),
                                  $urandom_range(1, n));
        end
    endtask

    // Compose or invert over distinct positions, usually closed by a commit.
    task automatic build_result(input logic [2:0] cmd, input int n);
        int m;
        m = (n > STREAM_MAX) ? STREAM_MAX : n;
        shuffle_points(n);
        for (int i = 0; i < m; i++)
            send_item(cmd, shuffle_buf[i], pick_image(n));
        if ($urandom_range(0, 3) != 0)
            send_item(pte_pkg::CMD_COMMIT, $urandom_range(1, MAX_POINTS),
                      $urandom_range(1, MAX_POINTS));
    endtask

    // Arbitrary commands and fields, including codes and positions out of range.
    task automatic noise_items();
        int pos;
        int val;
        repeat ($urandom_range(4, 16)) begin
            pos = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 511)
                                              : $urandom_range(1, MAX_POINTS);
            val = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 511)
                                              : $urandom_range(1, MAX_POINTS);
            send_item(3'($urandom_range(0, 7)), pos, val);
        end
    endtask

    // Stimulus.
    initial
    begin
        int r;
        int n;
        rst_n = 1'b0;
        in_valid = 1'b0;
        command = pte_pkg::CMD_LOAD;
        position = '0;
        image_value = '0;
        cfg_valid = 1'b0;
        cfg_data = '0;
        cur_size = 2;
        counted_items = 0;
        idle_on = 1'b1;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        // Reset size of two: identity reads, a position above it, a value beyond it.
        send_item(pte_pkg::CMD_READ, 1, 1);
        send_item(pte_pkg::CMD_READ, 3, 1);
        send_item(pte_pkg::CMD_APPLY, 1, 3);

        // Full size: extreme entries, every command, both bank flips.
        write_size(MAX_POINTS);
        send_item(pte_pkg::CMD_LOAD, 256, 1);
        send_item(pte_pkg::CMD_LOAD, 1, 256);
        send_item(pte_pkg::CMD_READ, 256, 0);
        send_item(pte_pkg::CMD_APPLY, 0, 256);
        send_item(pte_pkg::CMD_APPLY, 0, 1);
        send_item(pte_pkg::CMD_COMPOSE, 5, 256);
        send_item(pte_pkg::CMD_INVERT, 1, 0);
        send_item(pte_pkg::CMD_COMMIT, 0, 0);
        send_item(pte_pkg::CMD_READ, 5, 0);
        send_item(pte_pkg::CMD_READ, 256, 0);
        send_item(pte_pkg::CMD_COMMIT, 511, 511);
        send_item(pte_pkg::CMD_READ, 1, 0);
        send_item(3'd6, 1, 1);
        send_item(3'd7, 511, 511);
        send_item(pte_pkg::CMD_LOAD, 0, 7);
        send_item(pte_pkg::CMD_READ, 511, 0);

        // Single point: the stored image 256 is now beyond the size, so invert skips.
        write_size(1);
        send_item(pte_pkg::CMD_READ, 2, 0);
        send_item(pte_pkg::CMD_APPLY, 0, 2);
        send_item(pte_pkg::CMD_INVERT, 1, 0);
        send_item(pte_pkg::CMD_COMPOSE, 1, 1);

        // Random phases, each with its own point count.
        counted_items = 0;
        while (counted_items < TARGET_ITEMS) begin
            r = $urandom_range(0, 99);
            if (r < 15)
                n = MAX_POINTS;
            else if (r < 25)
                n = 1;
            else if (r < 35)
                n = 2;
            else if (r < 80)
                n = $urandom_range(3, 16);
            else
                n = $urandom_range(17, MAX_POINTS - 1);
            write_size(n);
            idle_on = ($urandom_range(0, 3) != 0);
            repeat ($urandom_range(3, 8)) begin
                case ($urandom_range(0, 9))
                    0, 1: load_permutation(n);
                    2, 3: repeat ($urandom_range(4, 24)) send_item(pte_pkg::CMD_APPLY,
                              $urandom_range(0, 511), pick_image(n));
                    4, 5: build_result(pte_pkg::CMD_COMPOSE, n);
                    6:    build_result(pte_pkg::CMD_INVERT, n);
                    7:    repeat ($urandom_range(4, 12)) send_item(pte_pkg::CMD_READ,
                              ($urandom_range(0, 9) == 0) ? $urandom_range(1, MAX_POINTS)
                                                          : $urandom_range(1, n),
                              $urandom_range(0, 511));
                    default: noise_items();
                endcase
            end
        end

        // Wait out the pipeline, then give the verdict.
        drain_results();
        repeat (8) @(posedge clk);
        if (fail_count == 0 && outstanding == 0)
            $display("[permutation_table_engine_core] OK");
        else
            $display("[permutation_table_engine_core] ERROR");
        $finish;
    end

endmodule

[files.f]
rtl/pte_pkg.sv
rtl/permutation_table_engine_core.sv
sim/permutation_table_monitor.sv
sim/tb_permutation_table_engine_core.sv
